### sv/fcs_pkg.sv
// Package for the fan command supervisor: request, state, result and register types,
// request and register codes, and the setpoint clamp. No dependencies.
package fcs_pkg;

    localparam int FREQ_W = 16;
    localparam int TIME_W = 4;
    localparam int CFG_INDEX_W = 2;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_OPEN  = 2'd1;
    localparam logic [1:0] REQ_CLOSE = 2'd2;
    localparam logic [1:0] REQ_SET   = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VARIABLE_SPEED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FREQUENCY  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FREQUENCY  = 2'd2;

    localparam logic [TIME_W-1:0] MISMATCH_STEP  = 4'd2;
    localparam logic [TIME_W-1:0] MISMATCH_LIMIT = 4'd10;
    localparam logic [FREQ_W:0]   FREQ_TOLERANCE = 17'd10;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [FREQ_W-1:0] requested_frequency;
        logic              running_feedback;
        logic              drive_fault;
        logic              remote_mode;
        logic [FREQ_W-1:0] measured_frequency;
    } t_item;

    typedef struct packed {
        logic              cmd_state;
        logic              relay_level;
        logic [FREQ_W-1:0] setpoint;
        logic              pending_check;
        logic [TIME_W-1:0] mismatch_time;
        logic              ctrl_fault_latch;
    } t_state;

    typedef struct packed {
        logic              variable_speed;
        logic [FREQ_W-1:0] min_frequency;
        logic [FREQ_W-1:0] max_frequency;
    } t_cfg;

    typedef struct packed {
        logic              relay_on;
        logic              command_on;
        logic              freq_write;
        logic [FREQ_W-1:0] freq_value;
        logic              control_fault;
        logic              check_pending;
    } t_result;

    // Raise to min, then lower to max (an inverted range ends at max).
    function automatic logic [FREQ_W-1:0] clamp_freq(
        input logic [FREQ_W-1:0] f,
        input logic [FREQ_W-1:0] lo,
        input logic [FREQ_W-1:0] hi
    );
        logic [FREQ_W-1:0] v;
        v = (f < lo) ? lo : f;
        if (v > hi) begin
            v = hi;
        end
        return v;
    endfunction

endpackage

### sv/fcs_in_stage.sv
// Input register for the fan command supervisor: holds one accepted request.
// Depends on fcs_pkg.
module fcs_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fcs_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_valid,
    output fcs_pkg::t_item o_item
);

    logic           r_valid;
    fcs_pkg::t_item r_item;

    // take a new request when empty or when the held one moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### sv/fcs_step.sv
// Next-state and result logic for one request of the fan command supervisor.
// Purely combinational. Depends on fcs_pkg.
module fcs_step (
    input  fcs_pkg::t_item   i_item,
    input  fcs_pkg::t_state  i_state,
    input  fcs_pkg::t_cfg    i_cfg,
    output fcs_pkg::t_state  o_state,
    output fcs_pkg::t_result o_result
);

    logic [fcs_pkg::FREQ_W:0] diff_up;
    logic [fcs_pkg::FREQ_W:0] diff_dn;
    logic                     off_target;

    assign diff_up = {1'b0, i_state.setpoint} - {1'b0, i_item.measured_frequency};
    assign diff_dn = {1'b0, i_item.measured_frequency} - {1'b0, i_state.setpoint};
    assign off_target = diff_up[fcs_pkg::FREQ_W] ? (diff_dn > fcs_pkg::FREQ_TOLERANCE)
                                                 : (diff_up > fcs_pkg::FREQ_TOLERANCE);

    always_comb begin
        fcs_pkg::t_state           s;
        logic                      run;
        logic                      flt;
        logic                      rem;
        logic                      do_apply;
        logic                      apply_cmd;
        logic [fcs_pkg::FREQ_W-1:0] apply_src;
        logic [fcs_pkg::FREQ_W-1:0] sp;
        logic                      wr;

        s         = i_state;
        run       = i_item.running_feedback;
        flt       = i_item.drive_fault;
        rem       = i_item.remote_mode;
        do_apply  = 1'b0;
        apply_cmd = 1'b0;
        apply_src = i_state.setpoint;
        sp        = '0;
        wr        = 1'b0;

        case (i_item.req_type)
            fcs_pkg::REQ_TICK: begin
                // commanded on but not running: retry the open
                if (s.cmd_state && !run && !flt && rem) begin
                    s.pending_check = 1'b1;
                    s.relay_level   = 1'b1;
                    do_apply        = i_cfg.variable_speed;
                    apply_cmd       = 1'b1;
                end
                // commanded off but running: retry the close
                if (!s.cmd_state && run) begin
                    s.pending_check = 1'b1;
                    s.relay_level   = 1'b0;
                end
                if (s.pending_check && rem) begin
                    if (s.cmd_state != run) begin
                        s.mismatch_time = s.mismatch_time + fcs_pkg::MISMATCH_STEP;
                    end else begin
                        s.pending_check = 1'b0;
                        s.mismatch_time = '0;
                    end
                end
                if (s.mismatch_time >= fcs_pkg::MISMATCH_LIMIT && s.pending_check && rem) begin
                    s.mismatch_time    = '0;
                    s.ctrl_fault_latch = 1'b1;
                    s.pending_check    = 1'b0;
                end
                // forced off
                if (flt || !rem || s.ctrl_fault_latch) begin
                    s.cmd_state     = 1'b0;
                    s.pending_check = 1'b0;
                    if (run) begin
                        s.relay_level = 1'b0;
                    end
                end
                // running drive off target: send setpoint again
                if (i_cfg.variable_speed && !flt && s.cmd_state && run && off_target) begin
                    do_apply  = 1'b1;
                    apply_cmd = 1'b1;
                end
            end
            fcs_pkg::REQ_OPEN: begin
                if (!flt && rem) begin
                    s.relay_level = 1'b1;
                    s.cmd_state   = 1'b1;
                    do_apply      = !run && i_cfg.variable_speed;
                    apply_cmd     = 1'b1;
                end
            end
            fcs_pkg::REQ_CLOSE: begin
                s.relay_level = 1'b0;
                s.cmd_state   = 1'b0;
            end
            fcs_pkg::REQ_SET: begin
                do_apply  = 1'b1;
                apply_cmd = i_state.cmd_state;
                apply_src = i_item.requested_frequency;
            end
            default: begin
                s = i_state;
            end
        endcase

        // at most one frequency send per request
        if (do_apply && i_cfg.variable_speed && !flt) begin
            sp         = fcs_pkg::clamp_freq(apply_src, i_cfg.min_frequency,
                                             i_cfg.max_frequency);
            s.setpoint = sp;
            wr         = apply_cmd && (i_item.measured_frequency != sp);
        end

        o_state                = s;
        o_result.relay_on      = s.relay_level;
        o_result.command_on    = s.cmd_state;
        o_result.freq_write    = wr;
        o_result.freq_value    = wr ? sp : '0;
        o_result.control_fault = s.ctrl_fault_latch;
        o_result.check_pending = s.pending_check;
    end

endmodule

### sv/fan_command_supervisor.sv
// Top level of the fan command supervisor: ports, register file, state and result register.
// Depends on fcs_pkg, fcs_in_stage and fcs_step.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------------
//  in      | to block  | i_in_valid / o_in_ready  | request kind, setpoint, sampled inputs
//  out     | from block| o_out_valid / i_out_ready| relay, command, freq write, fault, pending
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| register index (2 bits), data (16 bits)
//
// One request per cycle sustained while the output is not stalled; a request passes the
// input register, then the result register. The state update is one combinational pass.
// A request moves from the input register to the result register when the result
// register is empty or is being taken; a stalled output holds one result plus one request.
// Reset (i_rst_n low, synchronous) clears all supervisor state and sets the registers to
// variable_speed 0, min 0, max 65535. The cfg channel is always ready.
module fan_command_supervisor (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_requested_frequency,
    input  logic        i_running_feedback,
    input  logic        i_drive_fault,
    input  logic        i_remote_mode,
    input  logic [15:0] i_measured_frequency,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_relay_on,
    output logic        o_command_on,
    output logic        o_freq_write,
    output logic [15:0] o_freq_value,
    output logic        o_control_fault,
    output logic        o_check_pending,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    fcs_pkg::t_item   in_item;
    fcs_pkg::t_item   held_item;
    logic             held_valid;
    logic             advance;

    fcs_pkg::t_cfg    r_cfg;
    fcs_pkg::t_state  r_state;
    fcs_pkg::t_state  n_state;
    fcs_pkg::t_result r_out;
    fcs_pkg::t_result n_out;
    logic             r_out_valid;

    // ---- input register ----
    assign in_item.req_type            = i_req_type;
    assign in_item.requested_frequency = i_requested_frequency;
    assign in_item.running_feedback    = i_running_feedback;
    assign in_item.drive_fault         = i_drive_fault;
    assign in_item.remote_mode         = i_remote_mode;
    assign in_item.measured_frequency  = i_measured_frequency;

    // held request is processed when the result slot is free or draining
    assign advance = held_valid && (!r_out_valid || i_out_ready);

    fcs_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (in_item),
        .i_advance(advance),
        .o_valid  (held_valid),
        .o_item   (held_item)
    );

    // ---- configuration registers; unknown index is dropped ----
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.variable_speed <= 1'b0;
            r_cfg.min_frequency  <= '0;
            r_cfg.max_frequency  <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fcs_pkg::CFG_VARIABLE_SPEED: r_cfg.variable_speed <= i_cfg_data[0];
                fcs_pkg::CFG_MIN_FREQUENCY:  r_cfg.min_frequency  <= i_cfg_data;
                fcs_pkg::CFG_MAX_FREQUENCY:  r_cfg.max_frequency  <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // ---- supervisor update ----
    fcs_step u_step (
        .i_item  (held_item),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_result(n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_relay_on      = r_out.relay_on;
    assign o_command_on    = r_out.command_on;
    assign o_freq_write    = r_out.freq_write;
    assign o_freq_value    = r_out.freq_value;
    assign o_control_fault = r_out.control_fault;
    assign o_check_pending = r_out.check_pending;

    // ---- assertions ----
    // control fault never clears once latched
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ctrl_fault_latch |=> r_state.ctrl_fault_latch)
        else $error("control fault latch cleared");

    // mismatch timer only moves in steps of two
    a_timer_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.mismatch_time[0])
        else $error("mismatch timer odd");

    // no frequency value without a write
    a_freq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_freq_write) |-> (o_freq_value == 16'd0))
        else $error("frequency value without write");

    // state changes only when a request is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without a request");

endmodule

### sim/fan_command_supervisor_test.sv
// Testbench for fan_command_supervisor: directed and random requests checked against
// an in-bench prediction of the supervisor state. Depends on fcs_pkg and the block.
module fan_command_supervisor_test;

    // index with no register behind it; writes to it must be dropped
    localparam logic [fcs_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = fcs_pkg::REQ_TICK;
    logic [15:0] i_requested_frequency = '0;
    logic        i_running_feedback = 1'b0;
    logic        i_drive_fault = 1'b0;
    logic        i_remote_mode = 1'b0;
    logic [15:0] i_measured_frequency = '0;

    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_relay_on;
    logic        o_command_on;
    logic        o_freq_write;
    logic [15:0] o_freq_value;
    logic        o_control_fault;
    logic        o_check_pending;

    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = fcs_pkg::CFG_VARIABLE_SPEED;
    logic [15:0] i_cfg_data = '0;

    fan_command_supervisor u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_req_type            (i_req_type),
        .i_requested_frequency (i_requested_frequency),
        .i_running_feedback    (i_running_feedback),
        .i_drive_fault         (i_drive_fault),
        .i_remote_mode         (i_remote_mode),
        .i_measured_frequency  (i_measured_frequency),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_relay_on            (o_relay_on),
        .o_command_on          (o_command_on),
        .o_freq_write          (o_freq_write),
        .o_freq_value          (o_freq_value),
        .o_control_fault       (o_control_fault),
        .o_check_pending       (o_check_pending),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Bench copy of the supervisor: registers, state, and the frequency send
    // of the request being evaluated.
    fcs_pkg::t_cfg              regs = '{variable_speed: 1'b0, min_frequency: 16'h0000,
                                         max_frequency: 16'hFFFF};
    fcs_pkg::t_state            fan = '0;
    logic                       freq_sent;
    logic [fcs_pkg::FREQ_W-1:0] freq_sent_value;

    fcs_pkg::t_result status_queue[$];   // predicted status words, oldest first
    int      errors = 0;
    int      cycle_count = 0;

    // traffic shaping
    int   gap_pct = 0;          // chance per cycle that the sender stays idle
    int   stall_pct = 0;        // chance per cycle that the receiver stalls
    int   hold_len = 0;         // remaining cycles of a forced receiver hold-off
    logic plant_run = 1'b0;     // simulated run contact of the fan
    bit   spare_fault = 1'b1;   // keep random traffic away from the fault latch

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp to [min, max] in that order (an inverted range lands on max),
    // store as the setpoint, and send it if the fan is commanded on and the
    // drive is not already there.
    function automatic void apply_setpoint(fcs_pkg::t_item it,
                                           logic [fcs_pkg::FREQ_W-1:0] f);
        if (regs.variable_speed && !it.drive_fault) begin
            if (f < regs.min_frequency) begin
                f = regs.min_frequency;
            end
            if (f > regs.max_frequency) begin
                f = regs.max_frequency;
            end
            fan.setpoint = f;
            if (fan.cmd_state && it.measured_frequency != f) begin
                freq_sent = 1'b1;
                freq_sent_value = f;
            end
        end
    endfunction

    function automatic void open_fan(fcs_pkg::t_item it);
        if (!it.drive_fault && it.remote_mode) begin
            fan.relay_level = 1'b1;
            fan.cmd_state = 1'b1;
            // a stopped VFD fan gets its setpoint again
            if (!it.running_feedback && regs.variable_speed) begin
                apply_setpoint(it, fan.setpoint);
            end
        end
    endfunction

    function automatic void close_fan();
        fan.relay_level = 1'b0;
        fan.cmd_state = 1'b0;
    endfunction

    function automatic void supervise_tick(fcs_pkg::t_item it);
        logic [fcs_pkg::FREQ_W:0] drift;
        // re-issue commands the feedback has not followed
        if (fan.cmd_state && !it.running_feedback && !it.drive_fault && it.remote_mode) begin
            fan.pending_check = 1'b1;
            open_fan(it);
        end
        if (!fan.cmd_state && it.running_feedback) begin
            fan.pending_check = 1'b1;
            close_fan();
        end
        // time the disagreement
        if (fan.pending_check && it.remote_mode) begin
            if (fan.cmd_state != it.running_feedback) begin
                fan.mismatch_time = fan.mismatch_time + fcs_pkg::MISMATCH_STEP;
            end else begin
                fan.pending_check = 1'b0;
                fan.mismatch_time = '0;
            end
        end
        if (fan.mismatch_time >= fcs_pkg::MISMATCH_LIMIT && fan.pending_check
                && it.remote_mode) begin
            fan.mismatch_time = '0;
            fan.ctrl_fault_latch = 1'b1;
            fan.pending_check = 1'b0;
        end
        // forced off; a stopped fan keeps its relay level, timer is left alone
        if (it.drive_fault || !it.remote_mode || fan.ctrl_fault_latch) begin
            fan.cmd_state = 1'b0;
            fan.pending_check = 1'b0;
            if (it.running_feedback) begin
                close_fan();
            end
        end
        // drive drifted off the setpoint by more than the tolerance
        if (regs.variable_speed && !it.drive_fault && fan.cmd_state && it.running_feedback) begin
            drift = (fan.setpoint > it.measured_frequency)
                  ? {1'b0, fan.setpoint} - {1'b0, it.measured_frequency}
                  : {1'b0, it.measured_frequency} - {1'b0, fan.setpoint};
            if (drift > fcs_pkg::FREQ_TOLERANCE) begin
                apply_setpoint(it, fan.setpoint);
            end
        end
    endfunction

    function automatic fcs_pkg::t_result supervise_step(fcs_pkg::t_item it);
        fcs_pkg::t_result r;
        freq_sent = 1'b0;
        freq_sent_value = '0;
        case (it.req_type)
            fcs_pkg::REQ_TICK: begin
                supervise_tick(it);
            end
            fcs_pkg::REQ_OPEN: begin
                open_fan(it);
            end
            fcs_pkg::REQ_CLOSE: begin
                close_fan();
            end
            fcs_pkg::REQ_SET: begin
                apply_setpoint(it, it.requested_frequency);
            end
            default: ;
        endcase
        r.relay_on      = fan.relay_level;
        r.command_on    = fan.cmd_state;
        r.freq_write    = freq_sent;
        r.freq_value    = freq_sent ? freq_sent_value : '0;
        r.control_fault = fan.ctrl_fault_latch;
        r.check_pending = fan.pending_check;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request building
    // ------------------------------------------------------------------

    function automatic fcs_pkg::t_item fan_req(logic [1:0] kind, logic [15:0] freq,
                                               logic run, logic flt, logic remote,
                                               logic [15:0] meas);
        fcs_pkg::t_item it;
        it.req_type            = kind;
        it.requested_frequency = freq;
        it.running_feedback    = run;
        it.drive_fault         = flt;
        it.remote_mode         = remote;
        it.measured_frequency  = meas;
        return it;
    endfunction

    // Mostly plausible plant behavior: the run contact follows the command with
    // some lag, the drive sits near the setpoint, remote and healthy. Noise
    // requests are fully random.
    function automatic fcs_pkg::t_item random_request(bit noise);
        fcs_pkg::t_item it;
        int             pick;
        if (noise) begin
            it = fan_req(2'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), 16'($urandom));
        end else begin
            pick = $urandom_range(99);
            it.req_type = (pick < 45) ? fcs_pkg::REQ_TICK : (pick < 60) ? fcs_pkg::REQ_OPEN :
                          (pick < 70) ? fcs_pkg::REQ_CLOSE : fcs_pkg::REQ_SET;
            case ($urandom_range(9))
                0:       it.requested_frequency = 16'h0000;
                1:       it.requested_frequency = 16'hFFFF;
                2, 3:    it.requested_frequency = 16'($urandom_range(regs.max_frequency,
                                                                     regs.min_frequency));
                default: it.requested_frequency = 16'($urandom);
            endcase
            if ($urandom_range(99) < 80) begin
                plant_run = fan.cmd_state;
            end
            it.running_feedback = plant_run;
            it.drive_fault = ($urandom_range(99) < 3);
            it.remote_mode = ($urandom_range(99) >= 5);
            pick = $urandom_range(9);
            if (pick < 6) begin
                it.measured_frequency = fan.setpoint + 16'($urandom_range(40)) - 16'd20;
            end else if (pick < 8) begin
                it.measured_frequency = fan.setpoint;
            end else begin
                it.measured_frequency = 16'($urandom);
            end
        end
        // one more disagreeing tick would latch the fault for the rest of the run
        if (spare_fault && fan.mismatch_time >= 4'd8) begin
            it.running_feedback = fan.cmd_state;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one request and hold it until taken; predict at the accepting edge.
    // Valid is left high for a back-to-back request unless an idle gap is drawn.
    task automatic send_request(fcs_pkg::t_item it);
        i_in_valid            <= 1'b1;
        i_req_type            <= it.req_type;
        i_requested_frequency <= it.requested_frequency;
        i_running_feedback    <= it.running_feedback;
        i_drive_fault         <= it.drive_fault;
        i_remote_mode         <= it.remote_mode;
        i_measured_frequency  <= it.measured_frequency;
        do @(posedge i_clk); while (!o_in_ready);
        status_queue.push_back(supervise_step(it));
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    // Stop offering and let every predicted status come back, plus the
    // two-stage pipeline and a little margin.
    task automatic finish_burst();
        i_in_valid <= 1'b0;
        while (status_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves i_cfg_valid high so writes can run back to back.
    task automatic write_register(logic [fcs_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            fcs_pkg::CFG_VARIABLE_SPEED: regs.variable_speed = data[0];
            fcs_pkg::CFG_MIN_FREQUENCY:  regs.min_frequency = data;
            fcs_pkg::CFG_MAX_FREQUENCY:  regs.max_frequency = data;
            default: ;
        endcase
    endtask

    // Only called with the block idle. Upper data bits of the speed flag and
    // a write to the unused index are random and must not matter.
    task automatic configure(logic vs, logic [15:0] lo, logic [15:0] hi);
        logic [15:0] flag_word;
        flag_word = 16'($urandom);
        flag_word[0] = vs;
        write_register(fcs_pkg::CFG_VARIABLE_SPEED, flag_word);
        write_register(fcs_pkg::CFG_MIN_FREQUENCY, lo);
        write_register(fcs_pkg::CFG_MAX_FREQUENCY, hi);
        write_register(CFG_UNUSED, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            i_out_ready <= 1'b0;
            hold_len <= hold_len - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_status
        fcs_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (status_queue.size() == 0) begin
                errors++;
                $display("%0t: status returned with no request outstanding", $time);
            end else begin
                want = status_queue.pop_front();
                compare_field("relay_on", want.relay_on, o_relay_on);
                compare_field("command_on", want.command_on, o_command_on);
                compare_field("freq_write", want.freq_write, o_freq_write);
                compare_field("freq_value", want.freq_value, o_freq_value);
                compare_field("control_fault", want.control_fault, o_control_fault);
                compare_field("check_pending", want.check_pending, o_check_pending);
            end
        end
    end

    // Watchdog: a hung handshake or a lost status ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fan_command_supervisor test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset: fixed-speed, so setpoints are ignored.
    task automatic test_reset_defaults();
        send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000));
        send_request(fan_req(fcs_pkg::REQ_SET, 16'hFFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF));
        send_request(fan_req(fcs_pkg::REQ_OPEN, 16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000));
        send_request(fan_req(fcs_pkg::REQ_CLOSE, 16'hFFFF, 1'b1, 1'b1, 1'b0, 16'hFFFF));
        finish_burst();
    endtask

    // Setpoints outside the range are pulled in; nothing is sent while off.
    task automatic test_setpoint_clamp();
        configure(1'b1, 16'd100, 16'd60000);
        send_request(fan_req(fcs_pkg::REQ_SET, 16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000));
        send_request(fan_req(fcs_pkg::REQ_SET, 16'hFFFF, 1'b0, 1'b0, 1'b1, 16'h0000));
        finish_burst();
    endtask

    // Open is refused on a drive fault and in local mode.
    task automatic test_open_guards();
        send_request(fan_req(fcs_pkg::REQ_OPEN, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000));
        send_request(fan_req(fcs_pkg::REQ_OPEN, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000));
        send_request(fan_req(fcs_pkg::REQ_OPEN, 16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000));
        finish_burst();
    endtask

    // With the command on: send on change, hold when the drive already matches,
    // ignore while the drive is faulted.
    task automatic test_setpoint_send();
        send_request(fan_req(fcs_pkg::REQ_SET, 16'hFFFF, 1'b1, 1'b0, 1'b1, 16'd1234));
        send_request(fan_req(fcs_pkg::REQ_SET, 16'd5000, 1'b1, 1'b0, 1'b1, 16'd5000));
        send_request(fan_req(fcs_pkg::REQ_SET, 16'd7000, 1'b1, 1'b1, 1'b1, 16'd0));
        finish_burst();
    endtask

    // Tick handling: re-open a stopped fan, tolerance edge, forced off in local
    // mode and on a drive fault (a stopped fan keeps its relay), stop a fan
    // that runs without command.
    task automatic test_tick_supervision();
        send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0));
        send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b1, 1'b0, 1'b1, 16'd5011));
        send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b1, 1'b0, 1'b1, 16'd5010));
        send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b1, 1'b0, 1'b0, 16'd5000));
        send_request(fan_req(fcs_pkg::REQ_OPEN, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0));
        send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b0, 1'b1, 1'b1, 16'd0));
        send_request(fan_req(fcs_pkg::REQ_CLOSE, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0));
        send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b1, 1'b0, 1'b1, 16'd0));
        send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0));
        finish_burst();
    endtask

    // min above max: everything clamps to max.
    task automatic test_inverted_range();
        configure(1'b1, 16'd40000, 16'd20000);
        send_request(fan_req(fcs_pkg::REQ_OPEN, 16'h0000, 1'b1, 1'b0, 1'b1, 16'd0));
        send_request(fan_req(fcs_pkg::REQ_SET, 16'd30000, 1'b1, 1'b0, 1'b1, 16'd0));
        send_request(fan_req(fcs_pkg::REQ_SET, 16'd10000, 1'b1, 1'b0, 1'b1, 16'd0));
        send_request(fan_req(fcs_pkg::REQ_SET, 16'd50000, 1'b1, 1'b0, 1'b1, 16'd20000));
        send_request(fan_req(fcs_pkg::REQ_CLOSE, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0));
        finish_burst();
    endtask

    task automatic run_random(int count);
        repeat (count) begin
            send_request(random_request($urandom_range(99) < 15));
        end
        finish_burst();
    endtask

    // Several register settings, extremes among them, run in turn under four
    // idling patterns.
    task automatic test_random_traffic();
        logic        vs_set[6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        logic [15:0] lo_set[6] = '{16'd0, 16'd1000, 16'd300, 16'd40000, 16'hFFFF, 16'd0};
        logic [15:0] hi_set[6] = '{16'hFFFF, 16'd5000, 16'd2000, 16'd20000, 16'hFFFF, 16'd0};
        int          gap_set[4] = '{0, 81, 0, 6};
        int          stall_set[4] = '{0, 0, 81, 6};
        for (int p = 0; p < 6; p++) begin
            configure(vs_set[p], lo_set[p], hi_set[p]);
            gap_pct = gap_set[p % 4];
            stall_pct = stall_set[p % 4];
            run_random(150);
        end
    endtask

    // Receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        configure(1'b1, 16'd500, 16'd50000);
        gap_pct = 0;
        stall_pct = 0;
        hold_len <= 400;
        run_random(40);
    endtask

    // Feedback never follows: fault latches on the fifth tick and then forces
    // the fan off for good. Random traffic continues with the latch set.
    task automatic test_control_fault_latch();
        spare_fault = 1'b0;
        gap_pct = 6;
        stall_pct = 6;
        send_request(fan_req(fcs_pkg::REQ_OPEN, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0));
        repeat (5) begin
            send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0));
        end
        send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b1, 1'b0, 1'b1, 16'd0));
        send_request(fan_req(fcs_pkg::REQ_OPEN, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0));
        send_request(fan_req(fcs_pkg::REQ_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0));
        run_random(80);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_setpoint_clamp();
        test_open_guards();
        test_setpoint_send();
        test_tick_supervision();
        test_inverted_range();
        test_random_traffic();
        test_output_backpressure();
        test_control_fault_latch();
        if (errors == 0) begin
            $display("fan_command_supervisor test passed");
        end else begin
            $display("fan_command_supervisor test failed");
        end
        $finish;
    end

endmodule

### files.f
sv/fcs_pkg.sv
sv/fcs_in_stage.sv
sv/fcs_step.sv
sv/fan_command_supervisor.sv
sim/fan_command_supervisor_test.sv
